// ===== hw/rtl/qti_pkg.sv =====
// Shared types and constants for the quadrilinear table interpolator.
package qti_pkg;

  // Default table size on each axis
  localparam int DEF_SIZE = 8;

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Weight of one in Q1.16, and the width of an axis factor that can hold it
  localparam int          FACT_W     = 17;
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

  // Accumulator: 32-bit signed entry times a weight product of up to 2^64
  localparam int ACC_W = 98;

  // Corner sequencing flags that travel with each pipeline slot
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } ctl_t;

  typedef logic [FACT_W-1:0] fact_t;

endpackage

// ===== hw/rtl/qti_mac.sv =====
// Weighted multiply-accumulate pipeline with the rounding output register.
module qti_mac
  import qti_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_t               ctl_in,
  input  fact_t              fact_in [4],
  input  logic signed [31:0] entry_in,
  output logic               adv,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value
);

  ctl_t ctl2_r, ctl3_r, ctl4_r, ctl5_r;
  logic done6_r, out_valid_r;
  logic out_en;

  logic signed [31:0]      e2_r, e3_r;
  logic [2*FACT_W-1:0]     f01_r, f23_r;
  logic [64:0]             wp3_r;
  logic signed [64:0]      plo4_r;
  logic signed [65:0]      phi4_r;
  logic signed [ACC_W-1:0] prod5_r, acc_r, acc_nxt;
  logic signed [ACC_W-1:0] rnd;
  logic signed [31:0]      out_data_r;

  // Output register loads when empty or being drained
  assign out_en = !out_valid_r || out_ready;

  // Pipeline moves unless a finished sum would run into a waiting result
  assign adv = out_en || !done6_r;

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r      <= '0;
      ctl3_r      <= '0;
      ctl4_r      <= '0;
      ctl5_r      <= '0;
      done6_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        ctl2_r  <= ctl_in;
        ctl3_r  <= ctl2_r;
        ctl4_r  <= ctl3_r;
        ctl5_r  <= ctl4_r;
        done6_r <= ctl5_r.valid && ctl5_r.last;
      end
      if (out_en) begin
        out_valid_r <= done6_r;
      end
    end
  end

  // Running sum over the corners of one query
  always_comb begin
    acc_nxt = acc_r;
    if (ctl5_r.valid) begin
      acc_nxt = (ctl5_r.first ? '0 : acc_r) + prod5_r;
    end
  end

  // Round half up: add 2^63, keep bits 95:64
  assign rnd = acc_r + (ACC_W'(1) <<< 63);

  // Datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // factor pairs
      e2_r   <= entry_in;
      f01_r  <= fact_in[0] * fact_in[1];
      f23_r  <= fact_in[2] * fact_in[3];
      // full weight product, at most 2^64
      e3_r   <= e2_r;
      wp3_r  <= {31'd0, f01_r} * {31'd0, f23_r};
      // two partial products of the entry
      plo4_r <= $signed({{33{e3_r[31]}}, e3_r}) * $signed({33'd0, wp3_r[31:0]});
      phi4_r <= $signed({{34{e3_r[31]}}, e3_r}) * $signed({33'd0, wp3_r[64:32]});
      // combine partials
      prod5_r <= ACC_W'(plo4_r) + (ACC_W'(phi4_r) <<< 32);
      acc_r   <= acc_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_en) begin
      out_data_r <= rnd[95:64];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_data_r;

endmodule

// ===== hw/rtl/quadrilinear_table_interpolation.sv =====
// Top level: table memory, corner sequencer and interpolation pipeline.
//
// Usage: one input channel (in_valid/in_ready) carries write and query
// transactions; one output channel (out_valid/out_ready) returns one
// Q16.16 result per query, in order. A write (req_type 0) stores
// in_entry_value at the lower indices and returns nothing; a write
// outside the table is dropped. A query (req_type 1) is taken, then its
// 16 corners are read from the single-port table memory one per cycle
// while the pipeline moves, and the input stays busy until the last read.
// Throughput: one write per cycle while the pipeline moves; the memory
// port bounds queries, and a new one can start while earlier ones are in flight.
// Query indices past an axis end saturate to the last index.
// Reset clears the sequencer and pipeline valid flags; table contents are
// undefined until written. When the receiver stalls, the result waits in
// the output register while the pipeline keeps moving; only when the next
// finished sum reaches the stage behind it does the whole pipeline freeze
// in place, so no transaction is lost or repeated. The input stays ready
// for writes and new queries only while the pipeline can move.
module quadrilinear_table_interpolation
  import qti_pkg::*;
#(
  parameter int X_SIZE = DEF_SIZE,
  parameter int Y_SIZE = DEF_SIZE,
  parameter int Z_SIZE = DEF_SIZE,
  parameter int W_SIZE = DEF_SIZE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [2:0]         in_x_lo,
  input  logic [2:0]         in_x_hi,
  input  logic [2:0]         in_y_lo,
  input  logic [2:0]         in_y_hi,
  input  logic [2:0]         in_z_lo,
  input  logic [2:0]         in_z_hi,
  input  logic [2:0]         in_w_lo,
  input  logic [2:0]         in_w_hi,
  input  logic [63:0]        in_weights,
  input  logic signed [31:0] in_entry_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value
);

  localparam int DEPTH = X_SIZE * Y_SIZE * Z_SIZE * W_SIZE;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [2:0] sat_idx(input logic [2:0] v, input int size);
    sat_idx = (int'(v) >= size) ? 3'(size - 1) : v;
  endfunction

  function automatic logic [AW-1:0] cell_of(input logic [2:0] x, input logic [2:0] y,
                                            input logic [2:0] z, input logic [2:0] w);
    cell_of = AW'(((int'(x) * Y_SIZE + int'(y)) * Z_SIZE + int'(z)) * W_SIZE + int'(w));
  endfunction

  logic        adv;
  logic        acc_in, wr_en, q_start;
  logic        seq_active_r;
  logic [3:0]  cnt_r;
  logic [2:0]  lo_r [4];
  logic [2:0]  hi_r [4];
  logic [15:0] d_r  [4];
  logic [2:0]  idx  [4];
  fact_t       fact [4];
  fact_t       fact1_r [4];
  ctl_t        ctl_iss, ctl1_r;
  logic [AW-1:0]      addr;
  logic signed [31:0] mem_q_r;
  logic [31:0]        mem [DEPTH];

  // Input handshake: port is free when no corners are pending and the pipeline can move
  assign in_ready = adv && !seq_active_r;
  assign acc_in   = in_valid && in_ready;
  assign q_start  = acc_in && (in_req_type == REQ_QUERY);
  assign wr_en    = acc_in && (in_req_type == REQ_WRITE)
                    && (int'(in_x_lo) < X_SIZE) && (int'(in_y_lo) < Y_SIZE)
                    && (int'(in_z_lo) < Z_SIZE) && (int'(in_w_lo) < W_SIZE);

  // Corner sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_active_r <= 1'b0;
      cnt_r        <= '0;
    end else if (q_start) begin
      seq_active_r <= 1'b1;
      cnt_r        <= '0;
    end else if (adv && seq_active_r) begin
      cnt_r <= cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        seq_active_r <= 1'b0;
      end
    end
  end

  // Query capture, indices saturated
  always_ff @(posedge clk) begin
    if (q_start) begin
      lo_r[0] <= sat_idx(in_x_lo, X_SIZE);
      hi_r[0] <= sat_idx(in_x_hi, X_SIZE);
      lo_r[1] <= sat_idx(in_y_lo, Y_SIZE);
      hi_r[1] <= sat_idx(in_y_hi, Y_SIZE);
      lo_r[2] <= sat_idx(in_z_lo, Z_SIZE);
      hi_r[2] <= sat_idx(in_z_hi, Z_SIZE);
      lo_r[3] <= sat_idx(in_w_lo, W_SIZE);
      hi_r[3] <= sat_idx(in_w_hi, W_SIZE);
      for (int a = 0; a < 4; a++) begin
        d_r[a] <= in_weights[16*a +: 16];
      end
    end
  end

  // Corner select: x follows counter bit 3, w bit 0
  always_comb begin
    for (int a = 0; a < 4; a++) begin
      idx[a]  = cnt_r[3-a] ? hi_r[a] : lo_r[a];
      fact[a] = cnt_r[3-a] ? {1'b0, d_r[a]} : WEIGHT_ONE - {1'b0, d_r[a]};
    end
    ctl_iss.valid = seq_active_r;
    ctl_iss.first = (cnt_r == 4'd0);
    ctl_iss.last  = (cnt_r == 4'd15);
  end

  assign addr = wr_en ? cell_of(in_x_lo, in_y_lo, in_z_lo, in_w_lo)
                      : cell_of(idx[0], idx[1], idx[2], idx[3]);

  // Table memory, single port
  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_en) begin
        mem[addr] <= in_entry_value;
      end
      mem_q_r <= mem[addr];
    end
  end

  // Flags and factors line up with the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (adv) begin
      ctl1_r <= ctl_iss;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fact1_r <= fact;
    end
  end

  qti_mac u_mac (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl_in           (ctl1_r),
    .fact_in          (fact1_r),
    .entry_in         (mem_q_r),
    .adv              (adv),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value)
  );

  // Checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    seq_active_r |-> !in_ready) else $error("input taken during corner reads");

  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_start |=> (seq_active_r && cnt_r == 4'd0)) else $error("query did not start");

  a_seq_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_active_r && adv && cnt_r == 4'd15) |=> !seq_active_r)
    else $error("sequencer overran 16 corners");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(cnt_r) && $stable(ctl1_r))) else $error("pipeline moved in stall");

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the quadrilinear table interpolator: driver tasks, predictor scoreboard, checks.
module tb_top
  import qti_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // One input transaction, all fields
  typedef struct {
    logic              req_type;
    logic [2:0]        lo [4];
    logic [2:0]        hi [4];
    logic [63:0]       weights;
    logic signed [31:0] entry_value;
  } interp_item_t;

  // Scoreboard: holds its own copy of the table and the queue of expected results
  class interp_scoreboard;
    logic [31:0] grid [4096];
    logic signed [31:0] expected_q [$];
    int mismatches;
    int checked;
    int writes_seen;
    int queries_seen;

    function new();
      mismatches = 0;
      checked = 0;
      writes_seen = 0;
      queries_seen = 0;
    endfunction

    // Exact weighted corner sum, rounded half up to Q16.16
    function logic signed [31:0] interpolate(interp_item_t it);
      logic [127:0] acc;
      logic [127:0] prod;
      logic [127:0] ext;
      logic [2:0] idx [4];
      logic [16:0] d;
      logic [31:0] e;
      acc = '0;
      for (int c = 0; c < 16; c++) begin
        prod = 128'd1;
        for (int a = 0; a < 4; a++) begin
          d = {1'b0, it.weights[16*a +: 16]};
          if ((c >> (3 - a)) & 1) begin
            idx[a] = it.hi[a];
            prod = prod * {111'd0, d};
          end else begin
            idx[a] = it.lo[a];
            prod = prod * {111'd0, WEIGHT_ONE - d};
          end
        end
        e = grid[{idx[0], idx[1], idx[2], idx[3]}];
        ext = {{96{e[31]}}, e};
        acc = acc + ext * prod;
      end
      acc = acc + (128'd1 << 63);
      return acc[95:64];
    endfunction

    // Accepted input transaction
    function void note_input(interp_item_t it);
      if (it.req_type == REQ_WRITE) begin
        grid[{it.lo[0], it.lo[1], it.lo[2], it.lo[3]}] = it.entry_value;
        writes_seen++;
      end else begin
        expected_q.push_back(interpolate(it));
        queries_seen++;
      end
    endfunction

    // Accepted result transaction
    function void check_result(logic signed [31:0] actual);
      logic signed [31:0] exp_val;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: %h", actual);
        return;
      end
      exp_val = expected_q.pop_front();
      checked++;
      if (actual !== exp_val) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result_value mismatch: expected %h actual %h", exp_val, actual);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [2:0] in_x_lo = '0, in_x_hi = '0, in_y_lo = '0, in_y_hi = '0;
  logic [2:0] in_z_lo = '0, in_z_hi = '0, in_w_lo = '0, in_w_hi = '0;
  logic [63:0] in_weights = '0;
  logic signed [31:0] in_entry_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_result_value;

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  bit written [4096];
  interp_scoreboard sb;

  always #5 clk = ~clk;

  quadrilinear_table_interpolation u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_x_lo(in_x_lo), .in_x_hi(in_x_hi), .in_y_lo(in_y_lo), .in_y_hi(in_y_hi),
    .in_z_lo(in_z_lo), .in_z_hi(in_z_hi), .in_w_lo(in_w_lo), .in_w_hi(in_w_hi),
    .in_weights(in_weights), .in_entry_value(in_entry_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_value(out_result_value)
  );

  // Receiver backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Monitor both channels at the rising edge
  always @(posedge clk) begin
    interp_item_t it;
    if (rst_n && in_valid && in_ready) begin
      it.req_type = in_req_type;
      it.lo[0] = in_x_lo; it.lo[1] = in_y_lo; it.lo[2] = in_z_lo; it.lo[3] = in_w_lo;
      it.hi[0] = in_x_hi; it.hi[1] = in_y_hi; it.hi[2] = in_z_hi; it.hi[3] = in_w_hi;
      it.weights = in_weights;
      it.entry_value = in_entry_value;
      sb.note_input(it);
    end
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_result_value);
  end

  // Drive one transaction; valid is only dropped when a gap is inserted
  task automatic send_item(interp_item_t it);
    @(negedge clk);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_req_type = it.req_type;
    in_x_lo = it.lo[0]; in_y_lo = it.lo[1]; in_z_lo = it.lo[2]; in_w_lo = it.lo[3];
    in_x_hi = it.hi[0]; in_y_hi = it.hi[1]; in_z_hi = it.hi[2]; in_w_hi = it.hi[3];
    in_weights = it.weights;
    in_entry_value = it.entry_value;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic interp_item_t random_item();
    interp_item_t it;
    it.req_type = 1'($urandom_range(1));
    for (int a = 0; a < 4; a++) begin
      it.lo[a] = 3'($urandom_range(7));
      it.hi[a] = 3'($urandom_range(7));
    end
    it.weights = {$urandom(), $urandom()};
    it.entry_value = $urandom();
    return it;
  endfunction

  function automatic logic [31:0] random_entry();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [63:0] random_weights();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    for (int a = 0; a < 4; a++)
      case ($urandom_range(7))
        0: w[16*a +: 16] = 16'h0000;
        1: w[16*a +: 16] = 16'hffff;
        default: ;
      endcase
    return w;
  endfunction

  function automatic bit corners_written(interp_item_t it);
    logic [2:0] idx [4];
    for (int c = 0; c < 16; c++) begin
      for (int a = 0; a < 4; a++)
        idx[a] = ((c >> (3 - a)) & 1) ? it.hi[a] : it.lo[a];
      if (!written[{idx[0], idx[1], idx[2], idx[3]}]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Write all 16 corners of a cell region; returns the transaction count
  task automatic write_region(logic [2:0] lo [4], logic [2:0] hi [4], bit extremes,
                              output int sent);
    interp_item_t it;
    sent = 0;
    for (int c = 0; c < 16; c++) begin
      it = random_item();
      it.req_type = REQ_WRITE;
      for (int a = 0; a < 4; a++)
        it.lo[a] = ((c >> (3 - a)) & 1) ? hi[a] : lo[a];
      it.entry_value = extremes ? ((c & 1) ? 32'h7fff_ffff : 32'h8000_0000)
                                : random_entry();
      written[{it.lo[0], it.lo[1], it.lo[2], it.lo[3]}] = 1;
      send_item(it);
      sent++;
    end
  endtask

  task automatic query_region(logic [2:0] lo [4], logic [2:0] hi [4], logic [63:0] w);
    interp_item_t it;
    it = random_item();
    it.req_type = REQ_QUERY;
    it.lo = lo;
    it.hi = hi;
    it.weights = w;
    send_item(it);
  endtask

  // Stimulus
  initial begin
    logic [2:0] rlo [4];
    logic [2:0] rhi [4];
    logic [2:0] one_lo [4];
    interp_item_t it;
    int sent;
    int items;
    int phase_target;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extreme entries at the far corners, extreme weights
    sender_idle_pct = 20;
    receiver_idle_pct = 65;
    for (int a = 0; a < 4; a++) begin
      rlo[a] = 3'd0;
      rhi[a] = 3'd7;
      one_lo[a] = 3'd7;
    end
    write_region(rlo, rhi, 1'b1, sent);
    query_region(rlo, rhi, 64'h0);
    query_region(rlo, rhi, 64'hffff_ffff_ffff_ffff);
    query_region(rlo, rhi, 64'h8000_8000_8000_8000);
    query_region(rlo, rhi, 64'h0000_ffff_0000_ffff);
    // weight of one: upper index repeated as the lower one
    query_region(one_lo, one_lo, random_weights());

    // Random: region fill, several queries, some noise
    items = 21;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 20; receiver_idle_pct = 65; end
        1: begin sender_idle_pct = 65; receiver_idle_pct = 20; end
        default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
      endcase
      phase_target = 21 + (phase + 1) * 510;
      while (items < phase_target) begin
        for (int a = 0; a < 4; a++) begin
          rlo[a] = 3'($urandom_range(7));
          rhi[a] = ($urandom_range(3) == 0) ? rlo[a] : 3'($urandom_range(7));
        end
        write_region(rlo, rhi, 1'b0, sent);
        items += sent;
        repeat ($urandom_range(6, 1)) begin
          query_region(rlo, rhi, random_weights());
          items++;
          if ($urandom_range(3) == 0) begin
            it = random_item();
            if (it.req_type == REQ_WRITE) begin
              written[{it.lo[0], it.lo[1], it.lo[2], it.lo[3]}] = 1;
              send_item(it);
              items++;
            end else if (corners_written(it)) begin
              send_item(it);
              items++;
            end
          end
        end
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d writes and %0d queries, %0d results checked, %0d mismatches.",
             sb.writes_seen, sb.queries_seen, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("timeout waiting for transactions");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
